@@ design/tmp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmp_pkg
// Shared types and constants for the trapezoid motion profile generator.
// ----------------------------------------------------------------------------
package tmp_pkg;

  localparam int FieldW      = 24;
  localparam int TimeBitsDef = 24;
  localparam int CfgIdxW     = 2;

  typedef enum logic [1:0] {
    CFG_DISTANCE = 2'd0,
    CFG_SPEED    = 2'd1,
    CFG_ACCEL    = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PH_ACCEL  = 2'd0,
    PH_CRUISE = 2'd1,
    PH_DECEL  = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  typedef enum logic {
    MODE_DIV  = 1'b0,
    MODE_SQRT = 1'b1
  } unit_mode_t;

  typedef struct packed {
    logic       start;
    unit_mode_t mode;
  } unit_req_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SA,
    S_VV,
    S_CLASS,
    S_WAIT,
    S_T1TRAP,
    S_AT,
    S_ATT,
    S_T2,
    S_VT,
    S_AVT,
    S_POS1,
    S_CRUISE,
    S_VA,
    S_T3,
    S_T3CHK,
    S_TVLO,
    S_TVHI,
    S_NV,
    S_VEL,
    S_VSQ,
    S_RGO,
    S_DEC,
    S_SQ1,
    S_T1TRI,
    S_SQ2,
    S_T2TRI,
    S_PEAK,
    S_TRIV,
    S_OUT
  } state_t;

endpackage

@@ design/tmp_shiftsub.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmp_shiftsub
// Shared shift-subtract unit: restoring 64/64 divide (one quotient bit per
// cycle) or 64-bit integer square root (one root bit per cycle).
// ----------------------------------------------------------------------------
module tmp_shiftsub (
  input  logic                  clk,
  input  logic                  rst,
  input  tmp_pkg::unit_req_t    req,
  input  logic [63:0]           num,
  input  logic [63:0]           den,
  output logic                  busy,
  output logic                  done,
  output logic [63:0]           result
);

  logic [65:0]        rem;
  logic [63:0]        acc;
  logic [63:0]        quo;
  logic [63:0]        den_q;
  logic [6:0]         count;
  tmp_pkg::unit_mode_t mode;

  logic [65:0] sh;
  logic [65:0] trial;
  logic [66:0] diff;
  logic        ge;
  logic [6:0]  last;

  always_comb begin
    if (mode == tmp_pkg::MODE_SQRT) begin
      sh    = {rem[63:0], acc[63:62]};
      trial = {32'd0, quo[31:0], 2'b01};
      last  = 7'd31;
    end else begin
      sh    = {rem[64:0], acc[63]};
      trial = {2'b00, den_q};
      last  = 7'd63;
    end
    diff = {1'b0, sh} - {1'b0, trial};
    ge   = !diff[66];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && count == last) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem   <= '0;
      quo   <= '0;
      acc   <= num;
      den_q <= den;
      count <= '0;
      mode  <= req.mode;
    end else if (busy) begin
      rem   <= ge ? diff[65:0] : sh;
      quo   <= {quo[62:0], ge};
      acc   <= (mode == tmp_pkg::MODE_SQRT) ? {acc[61:0], 2'b00} : {acc[62:0], 1'b0};
      count <= count + 7'd1;
    end
  end

  assign result = quo;

endmodule

@@ design/trapezoid_motion_profile.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trapezoid_motion_profile
// Trapezoidal / triangular velocity profile generator. Each input beat is one
// control tick; it yields reference position, velocity and phase.
//
//   channel  signals                               direction
//   in       in_valid, in_ready, restart           to block
//   out      out_valid, out_ready, ref_position,   from block
//            ref_velocity, phase
//   cfg      cfg_wen, cfg_addr, cfg_wdata          to block
//
// the time from one accept of a beat to the next is set by how many divides
// and square roots the shared shift-subtract unit runs (up to five divides in
// the decelerate phase of a trapezoid)
// rst is synchronous; it clears state, tick counter, config and out_valid
// in_ready is high only while no beat is at work
// a finished result waits in the output register while out_ready is low
// ----------------------------------------------------------------------------
module trapezoid_motion_profile #(
  parameter int TIME_BITS = tmp_pkg::TimeBitsDef
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        restart,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tmp_pkg::FieldW-1:0]  ref_position,
  output logic [tmp_pkg::FieldW-1:0]  ref_velocity,
  output logic [1:0]                  phase,
  input  logic                        cfg_wen,
  input  logic [tmp_pkg::CfgIdxW-1:0] cfg_addr,
  input  logic [tmp_pkg::FieldW-1:0]  cfg_wdata
);

  localparam int FW = tmp_pkg::FieldW;

  logic [FW-1:0]        target_distance;
  logic [FW-1:0]        peak_speed;
  logic [FW-1:0]        accel_rate;
  logic [TIME_BITS-1:0] elapsed;
  logic [TIME_BITS-1:0] t_cur;

  tmp_pkg::state_t state, state_next, ret, ret_next;

  logic [47:0] sa, vv, va;
  logic [63:0] prod;
  logic [63:0] vel;
  logic [63:0] res_pos, res_vel;
  tmp_pkg::phase_t res_phase;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_out;

  tmp_pkg::unit_req_t req;
  logic [63:0] u_num, u_den;
  logic        u_busy, u_done;
  logic [63:0] u_res;

  logic [63:0] t64;
  logic [31:0] t32;
  logic [48:0] svv;
  logic [63:0] num;
  logic [63:0] top;
  logic        t_le;
  logic        zero_cfg;
  logic        trap;
  logic [TIME_BITS-1:0] t_in;

  assign t64      = 64'(t_cur);
  assign t32      = 32'(t_cur);
  assign svv      = {1'b0, sa} + {1'b0, vv};
  assign num      = 64'({svv, 8'd0});
  assign top      = 64'({vel[31:0], 9'd0});
  assign t_le     = t64 <= u_res;
  assign zero_cfg = (peak_speed == '0) || (accel_rate == '0);
  assign trap     = sa > vv;
  assign t_in     = restart ? '0 : elapsed;
  assign mul_out  = 64'(mul_a) * 64'(mul_b);

  tmp_shiftsub u_shiftsub (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .num    (u_num),
    .den    (u_den),
    .busy   (u_busy),
    .done   (u_done),
    .result (u_res)
  );

  // next state
  always_comb begin
    state_next = state;
    ret_next   = ret;
    case (state)
      tmp_pkg::S_IDLE:   if (in_valid) state_next = tmp_pkg::S_SA;
      tmp_pkg::S_SA:     state_next = tmp_pkg::S_VV;
      tmp_pkg::S_VV:     state_next = tmp_pkg::S_CLASS;
      tmp_pkg::S_CLASS: begin
        if (zero_cfg) begin
          state_next = tmp_pkg::S_OUT;
        end else begin
          state_next = tmp_pkg::S_WAIT;
          ret_next   = trap ? tmp_pkg::S_T1TRAP : tmp_pkg::S_SQ1;
        end
      end
      tmp_pkg::S_WAIT:   if (u_done) state_next = ret;
      tmp_pkg::S_T1TRAP: begin
        if (t_le) begin
          state_next = tmp_pkg::S_AT;
        end else begin
          state_next = tmp_pkg::S_WAIT;
          ret_next   = tmp_pkg::S_T2;
        end
      end
      tmp_pkg::S_AT:     state_next = tmp_pkg::S_ATT;
      tmp_pkg::S_ATT:    state_next = tmp_pkg::S_OUT;
      tmp_pkg::S_T2:     state_next = t_le ? tmp_pkg::S_VT : tmp_pkg::S_VA;
      tmp_pkg::S_VT:     state_next = tmp_pkg::S_AVT;
      tmp_pkg::S_AVT:    state_next = tmp_pkg::S_POS1;
      tmp_pkg::S_POS1: begin
        state_next = tmp_pkg::S_WAIT;
        ret_next   = tmp_pkg::S_CRUISE;
      end
      tmp_pkg::S_CRUISE: state_next = tmp_pkg::S_OUT;
      tmp_pkg::S_VA:     state_next = tmp_pkg::S_T3;
      tmp_pkg::S_T3: begin
        state_next = tmp_pkg::S_WAIT;
        ret_next   = tmp_pkg::S_T3CHK;
      end
      tmp_pkg::S_T3CHK:  state_next = t_le ? tmp_pkg::S_TVLO : tmp_pkg::S_OUT;
      tmp_pkg::S_TVLO:   state_next = tmp_pkg::S_TVHI;
      tmp_pkg::S_TVHI:   state_next = tmp_pkg::S_NV;
      tmp_pkg::S_NV: begin
        state_next = tmp_pkg::S_WAIT;
        ret_next   = tmp_pkg::S_VEL;
      end
      tmp_pkg::S_VEL:    state_next = tmp_pkg::S_VSQ;
      tmp_pkg::S_VSQ:    state_next = tmp_pkg::S_RGO;
      tmp_pkg::S_RGO: begin
        state_next = tmp_pkg::S_WAIT;
        ret_next   = tmp_pkg::S_DEC;
      end
      tmp_pkg::S_DEC:    state_next = tmp_pkg::S_OUT;
      tmp_pkg::S_SQ1: begin
        state_next = tmp_pkg::S_WAIT;
        ret_next   = tmp_pkg::S_T1TRI;
      end
      tmp_pkg::S_T1TRI: begin
        if (t_le) begin
          state_next = tmp_pkg::S_AT;
        end else begin
          state_next = tmp_pkg::S_WAIT;
          ret_next   = tmp_pkg::S_SQ2;
        end
      end
      tmp_pkg::S_SQ2: begin
        state_next = tmp_pkg::S_WAIT;
        ret_next   = tmp_pkg::S_T2TRI;
      end
      tmp_pkg::S_T2TRI: begin
        if (t_le) begin
          state_next = tmp_pkg::S_WAIT;
          ret_next   = tmp_pkg::S_PEAK;
        end else begin
          state_next = tmp_pkg::S_OUT;
        end
      end
      tmp_pkg::S_PEAK:   state_next = tmp_pkg::S_TRIV;
      tmp_pkg::S_TRIV:   state_next = tmp_pkg::S_VSQ;
      tmp_pkg::S_OUT:    if (!out_valid || out_ready) state_next = tmp_pkg::S_IDLE;
      default:           state_next = tmp_pkg::S_IDLE;
    endcase
  end

  // outputs: handshake, multiplier and unit operands
  always_comb begin
    in_ready  = 1'b0;
    req.start = 1'b0;
    req.mode  = tmp_pkg::MODE_DIV;
    u_num     = '0;
    u_den     = '0;
    mul_a     = '0;
    mul_b     = '0;
    case (state)
      tmp_pkg::S_IDLE: in_ready = 1'b1;
      tmp_pkg::S_SA: begin
        mul_a = 32'(target_distance);
        mul_b = 32'(accel_rate);
      end
      tmp_pkg::S_VV: begin
        mul_a = 32'(peak_speed);
        mul_b = 32'(peak_speed);
      end
      tmp_pkg::S_CLASS: begin
        req.start = !zero_cfg;
        u_den     = 64'(accel_rate);
        u_num     = trap ? 64'({peak_speed, 8'd0}) : 64'({target_distance, 16'd0});
      end
      tmp_pkg::S_T1TRAP: begin
        req.start = !t_le;
        u_num     = 64'({target_distance, 8'd0});
        u_den     = 64'(peak_speed);
      end
      tmp_pkg::S_AT, tmp_pkg::S_PEAK: begin
        mul_a = 32'(accel_rate);
        mul_b = t32;
      end
      tmp_pkg::S_ATT: begin
        mul_a = prod[31:0];
        mul_b = t32;
      end
      tmp_pkg::S_VT: begin
        mul_a = 32'(peak_speed);
        mul_b = t32;
      end
      tmp_pkg::S_AVT: begin
        mul_a = 32'(accel_rate);
        mul_b = prod[31:0];
      end
      tmp_pkg::S_POS1: begin
        req.start = 1'b1;
        u_num     = {prod[62:0], 1'b0} - 64'({vv, 8'd0});
        u_den     = 64'({accel_rate, 9'd0});
      end
      tmp_pkg::S_VA: begin
        mul_a = 32'(peak_speed);
        mul_b = 32'(accel_rate);
      end
      tmp_pkg::S_T3: begin
        req.start = 1'b1;
        u_num     = num;
        u_den     = 64'(va);
      end
      tmp_pkg::S_TVLO: begin
        mul_a = t32;
        mul_b = va[31:0];
      end
      tmp_pkg::S_TVHI: begin
        mul_a = t32;
        mul_b = 32'(va[47:32]);
      end
      tmp_pkg::S_NV: begin
        req.start = 1'b1;
        u_num     = num - prod;
        u_den     = 64'({peak_speed, 8'd0});
      end
      tmp_pkg::S_VSQ: begin
        mul_a = vel[31:0];
        mul_b = vel[31:0];
      end
      tmp_pkg::S_RGO: begin
        req.start = 1'b1;
        u_num     = prod;
        u_den     = 64'({accel_rate, 1'b0});
      end
      tmp_pkg::S_SQ1, tmp_pkg::S_SQ2: begin
        req.start = 1'b1;
        req.mode  = tmp_pkg::MODE_SQRT;
        u_num     = u_res;
      end
      tmp_pkg::S_T1TRI: begin
        req.start = !t_le;
        u_num     = 64'({target_distance, 18'd0});
        u_den     = 64'(accel_rate);
      end
      tmp_pkg::S_T2TRI: begin
        req.start = t_le;
        req.mode  = tmp_pkg::MODE_SQRT;
        u_num     = 64'(sa);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= tmp_pkg::S_IDLE;
      ret             <= tmp_pkg::S_IDLE;
      elapsed         <= '0;
      target_distance <= '0;
      peak_speed      <= '0;
      accel_rate      <= '0;
    end else begin
      state <= state_next;
      ret   <= ret_next;
      if (in_valid && in_ready) begin
        elapsed <= (t_in == '1) ? t_in : t_in + 1'b1;
      end
      if (cfg_wen) begin
        case (cfg_addr)
          tmp_pkg::CFG_DISTANCE: target_distance <= cfg_wdata;
          tmp_pkg::CFG_SPEED:    peak_speed      <= cfg_wdata;
          tmp_pkg::CFG_ACCEL:    accel_rate      <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      tmp_pkg::S_IDLE: begin
        t_cur     <= t_in;
        res_pos   <= '0;
        res_vel   <= '0;
        res_phase <= tmp_pkg::PH_DONE;
      end
      tmp_pkg::S_SA: sa <= mul_out[47:0];
      tmp_pkg::S_VV: vv <= mul_out[47:0];
      tmp_pkg::S_AT, tmp_pkg::S_VT, tmp_pkg::S_AVT, tmp_pkg::S_VSQ, tmp_pkg::S_TVLO:
        prod <= mul_out;
      tmp_pkg::S_ATT: begin
        res_vel   <= {8'd0, prod[63:8]};
        res_pos   <= {17'd0, mul_out[63:17]};
        res_phase <= tmp_pkg::PH_ACCEL;
      end
      tmp_pkg::S_T2, tmp_pkg::S_T2TRI: begin
        res_pos <= 64'(target_distance);
      end
      tmp_pkg::S_T3CHK: res_pos <= 64'(target_distance);
      tmp_pkg::S_CRUISE: begin
        res_pos   <= u_res;
        res_vel   <= 64'(peak_speed);
        res_phase <= tmp_pkg::PH_CRUISE;
      end
      tmp_pkg::S_VA:   va <= mul_out[47:0];
      tmp_pkg::S_TVHI: prod <= prod + {mul_out[31:0], 32'd0};
      tmp_pkg::S_VEL:  vel <= u_res;
      tmp_pkg::S_DEC: begin
        res_pos   <= (u_res >= 64'(target_distance)) ? '0 : 64'(target_distance) - u_res;
        res_vel   <= vel;
        res_phase <= tmp_pkg::PH_DECEL;
      end
      tmp_pkg::S_PEAK: begin
        vel  <= u_res;
        prod <= mul_out;
      end
      tmp_pkg::S_TRIV: vel <= (top > prod) ? {8'd0, top[63:8] - prod[63:8] -
                                              56'(top[7:0] < prod[7:0])} : '0;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == tmp_pkg::S_OUT && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == tmp_pkg::S_OUT && (!out_valid || out_ready)) begin
      ref_position <= (res_pos > 64'(target_distance)) ? target_distance : res_pos[FW-1:0];
      ref_velocity <= (res_vel > 64'({FW{1'b1}})) ? {FW{1'b1}} : res_vel[FW-1:0];
      phase        <= res_phase;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (ref_position <= target_distance))
    else $error("position beyond target");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && phase == tmp_pkg::PH_DONE) |->
      (ref_position == target_distance || ref_position == '0))
    else $error("done phase with position short of target");

  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !restart) |=> (elapsed >= $past(elapsed)))
    else $error("tick counter went back without restart");

  assert property (@(posedge clk) disable iff (rst)
    (state == tmp_pkg::S_WAIT) |-> (u_busy || u_done))
    else $error("waiting on an idle shift-subtract unit");

endmodule
